@@ rtl/wbq_pkg.sv @@
// types and constants shared by the watermark backpressure queue
package wbq_pkg;

	// watermark register width, also the width of the reported fill level
	localparam int WATER_W = 11;

	// configuration register indexes
	localparam logic CFG_HIGH_WATER = 1'b0;
	localparam logic CFG_LOW_WATER  = 1'b1;

	// command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_SEND    = 1'b1;

	// result kinds
	localparam logic [2:0] KIND_SENT      = 3'd0;
	localparam logic [2:0] KIND_DROPPED   = 3'd1;
	localparam logic [2:0] KIND_OVERLOAD  = 3'd2;
	localparam logic [2:0] KIND_UNDERLOAD = 3'd3;
	localparam logic [2:0] KIND_EMPTY     = 3'd4;

	// header fields of messages and plain packets
	localparam logic [9:0] OPT_OVERLOAD  = 10'd765;
	localparam logic [9:0] OPT_UNDERLOAD = 10'd764;
	localparam logic [9:0] OPT_NONE      = 10'd0;
	localparam logic [2:0] WORDS_MSG     = 3'd6;
	localparam logic [2:0] WORDS_PLAIN   = 3'd5;

	// input word
	typedef struct packed {
		logic        cmd;
		logic [15:0] handle;
		logic [47:0] mac_src;
		logic [47:0] mac_dst;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
	} item_t;

	// one packet record held in the ring
	typedef struct packed {
		logic [15:0] handle;
		logic [47:0] mac_src;
		logic [47:0] mac_dst;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
	} rec_t;

	// result word
	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        out_handle;
		logic [47:0]        out_mac_dst;
		logic [47:0]        out_mac_src;
		logic [31:0]        out_ip_dst;
		logic [31:0]        out_ip_src;
		logic [2:0]         header_words;
		logic [9:0]         option_code;
		logic [WATER_W-1:0] fill_level;
		logic [31:0]        pause_total;
		logic [31:0]        resume_total;
		logic               last;
	} result_t;

endpackage

@@ rtl/watermark_backpressure_queue_core.sv @@
// packet ring with high and low watermark overload signalling
//
// Usage: an input word (enqueue or send slot) is taken at a clock edge with
// start high and busy low. Results leave on result, one per cycle, each
// marked by strobe for exactly one cycle; the receiver cannot stall them.
// An enqueue gives no result, or an overload message and/or a drop result.
// A send slot gives a sent or empty result, preceded by an underload
// message when the fill level falls below low_water while overloaded.
// A word's first result passes the stage register and ring read, then the
// result register. One result or none allows a new word every cycle; two
// results hold busy high for one cycle, so the word's two results take
// the single result port in turn.
// The ring is one QUEUE_DEPTH-entry memory with one write and one
// registered read per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 high_water,
// 1 low_water) and cfg_data; cfg_ready is always high.
// Reset: pointers, fill level, overload flag and counters clear and the
// watermarks return to 819 and 204; ring contents are not cleared and
// no clearing pass is needed.
module watermark_backpressure_queue_core #(
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  wbq_pkg::item_t             item,
	output logic                       strobe,
	output wbq_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [wbq_pkg::WATER_W-1:0] cfg_data
);
	import wbq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (OCC_W > WATER_W) ? OCC_W : WATER_W;

	// control state
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic               overload_q;
	logic [31:0]        pause_q;
	logic [31:0]        resume_q;
	logic [WATER_W-1:0] high_water_q;
	logic [WATER_W-1:0] low_water_q;

	// ring storage
	rec_t mem [QUEUE_DEPTH];

	// stage one: decoded item, ring read data, state snapshot
	logic               valid_s1;
	logic               cmd_s1;
	logic               msg_s1;
	logic               plain_s1;
	logic               empty_s1;
	logic               phase_s1;
	rec_t               in_s1;
	rec_t               rd_s1;
	logic [WATER_W-1:0] fill_s1;
	logic [31:0]        pause_s1;
	logic [31:0]        resume_s1;

	// result register
	result_t            result_q;
	logic               strobe_q;

	// next-state signals
	logic               accept;
	logic               is_enq;
	logic               full;
	logic               empty;
	logic               wr_en;
	logic [OCC_W-1:0]   occ_next;
	logic [CMP_W-1:0]   occ_ext;
	logic               over;
	logic               under;
	logic               has_msg;
	logic               has_plain;
	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   tail_inc;
	rec_t               in_rec;
	rec_t               src;
	logic               first_msg;
	logic               done;
	result_t            res_d;

	assign accept    = start && !busy;
	assign is_enq    = (item.cmd == CMD_ENQUEUE);
	assign full      = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign empty     = (occ_q == '0);
	assign wr_en     = accept && is_enq && !full;
	assign cfg_ready = 1'b1;

	assign in_rec = '{handle: item.handle, mac_src: item.mac_src, mac_dst: item.mac_dst,
		ip_src: item.ip_src, ip_dst: item.ip_dst};

	// pointer wrap at the ring depth
	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	// fill level after this word and watermark checks
	always_comb begin
		occ_next = occ_q;
		if (is_enq) begin
			if (!full)
				occ_next = occ_q + OCC_W'(1);
		end else if (!empty) begin
			occ_next = occ_q - OCC_W'(1);
		end
		occ_ext   = CMP_W'(occ_next);
		over      = is_enq && (occ_ext > CMP_W'(high_water_q));
		under     = !is_enq && !empty && overload_q && (occ_ext < CMP_W'(low_water_q));
		has_msg   = over || under;
		has_plain = is_enq ? full : 1'b1;
	end

	// second result still to go: hold off input for one cycle
	assign busy = valid_s1 && msg_s1 && plain_s1 && !phase_s1;
	assign done = valid_s1 && !busy;

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			overload_q <= 1'b0;
			pause_q    <= '0;
			resume_q   <= '0;
		end else if (accept) begin
			occ_q <= occ_next;
			if (wr_en)
				tail_q <= tail_inc;
			if (!is_enq && !empty)
				head_q <= head_inc;
			if (over) begin
				overload_q <= 1'b1;
				pause_q    <= pause_q + 32'd1;
			end
			if (under) begin
				overload_q <= 1'b0;
				resume_q   <= resume_q + 32'd1;
			end
		end
	end

	// watermark registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_water_q <= WATER_W'(819);
			low_water_q  <= WATER_W'(204);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HIGH_WATER: high_water_q <= cfg_data;
				CFG_LOW_WATER:  low_water_q  <= cfg_data;
				default:        high_water_q <= high_water_q;
			endcase
		end
	end

	// ring write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[tail_q] <= in_rec;
		if (accept)
			rd_s1 <= mem[head_q];
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= has_msg || has_plain;
			phase_s1 <= 1'b0;
		end else if (busy) begin
			phase_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= item.cmd;
			msg_s1    <= has_msg;
			plain_s1  <= has_plain;
			empty_s1  <= !is_enq && empty;
			in_s1     <= in_rec;
			fill_s1   <= occ_ext[WATER_W-1:0];
			pause_s1  <= over ? pause_q + 32'd1 : pause_q;
			resume_s1 <= under ? resume_q + 32'd1 : resume_q;
		end
	end

	// result formation from stage one
	assign src       = (cmd_s1 == CMD_SEND) ? rd_s1 : in_s1;
	assign first_msg = msg_s1 && !phase_s1;

	always_comb begin
		res_d              = '0;
		res_d.fill_level   = fill_s1;
		res_d.pause_total  = pause_s1;
		res_d.resume_total = resume_s1;
		res_d.last         = !(first_msg && plain_s1);
		if (empty_s1) begin
			res_d.kind         = KIND_EMPTY;
			res_d.header_words = WORDS_PLAIN;
			res_d.option_code  = OPT_NONE;
		end else if (first_msg) begin
			res_d.kind         = (cmd_s1 == CMD_SEND) ? KIND_UNDERLOAD : KIND_OVERLOAD;
			res_d.out_handle   = src.handle;
			res_d.out_mac_dst  = src.mac_src;
			res_d.out_mac_src  = src.mac_dst;
			res_d.out_ip_dst   = src.ip_src;
			res_d.out_ip_src   = src.ip_dst;
			res_d.header_words = WORDS_MSG;
			res_d.option_code  = (cmd_s1 == CMD_SEND) ? OPT_UNDERLOAD : OPT_OVERLOAD;
		end else begin
			res_d.kind         = (cmd_s1 == CMD_SEND) ? KIND_SENT : KIND_DROPPED;
			res_d.out_handle   = src.handle;
			res_d.out_mac_dst  = src.mac_dst;
			res_d.out_mac_src  = src.mac_src;
			res_d.out_ip_dst   = src.ip_dst;
			res_d.out_ip_src   = src.ip_src;
			res_d.header_words = WORDS_PLAIN;
			res_d.option_code  = OPT_NONE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			result_q <= res_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// fill level never passes the ring depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("fill level beyond ring depth");

	// a result that is not last is followed by another in the next cycle
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("second result of a word missing");

	// overload flag only rises on an accepted enqueue
	a_over_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overload_q) |-> $past(start && !busy && item.cmd == CMD_ENQUEUE))
		else $error("overload flag set without enqueue");
`endif

endmodule

@@ tb/tb_watermark_backpressure_queue_core.sv @@
// self-checking testbench for the watermark backpressure queue core
module tb_watermark_backpressure_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import wbq_pkg::*;

	localparam int QUEUE_DEPTH   = 1024;
	localparam int PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;

	localparam int REC_W = $bits(rec_t);

	// send slot words, payload unused by the block
	localparam item_t SLOT_ZERO = item_t'({CMD_SEND, {REC_W{1'b0}}});
	localparam item_t SLOT_ONES = item_t'({CMD_SEND, {REC_W{1'b1}}});

	// results read straight off the behavior
	localparam result_t EMPTY_AT_RESET = result_t'({KIND_EMPTY, 16'h0, 48'h0, 48'h0,
		32'h0, 32'h0, WORDS_PLAIN, OPT_NONE, 11'd0, 32'd0, 32'd0, 1'b1});
	localparam result_t FIRST_OVERLOAD_ONES = result_t'({KIND_OVERLOAD, 16'hffff,
		{48{1'b1}}, {48{1'b1}}, 32'hffff_ffff, 32'hffff_ffff, WORDS_MSG, OPT_OVERLOAD,
		11'd1, 32'd1, 32'd0, 1'b1});

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	item_t              item;
	logic               strobe;
	result_t            result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [WATER_W-1:0] cfg_data;

	watermark_backpressure_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.strobe   (strobe),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// shadow copy of the queue state and watermarks
	rec_t               shadow_ring [QUEUE_DEPTH];
	logic [PTR_W-1:0]   rd_ptr;
	logic [PTR_W-1:0]   wr_ptr;
	int                 held;
	bit                 overloaded;
	logic [31:0]        pauses;
	logic [31:0]        resumes;
	logic [WATER_W-1:0] hi_mark;
	logic [WATER_W-1:0] lo_mark;

	result_t            pkt_events_due [$];
	int                 mismatches;
	int                 cycles;

	// directed stimulus table
	typedef struct {
		bit                 is_cfg;
		logic [WATER_W-1:0] hi;
		logic [WATER_W-1:0] lo;
		item_t              w;
		bit                 has_lit;
		result_t            lit;
	} row_t;

	row_t script [$];

	function automatic item_t enq(input logic [15:0] h, input logic [47:0] ms,
		input logic [47:0] md, input logic [31:0] is, input logic [31:0] id);
		return item_t'({CMD_ENQUEUE, h, ms, md, is, id});
	endfunction

	// one result word built from the current shadow counters
	function automatic result_t make_event(input logic [2:0] kind, input logic [15:0] h,
		input logic [47:0] mdst, input logic [47:0] msrc, input logic [31:0] idst,
		input logic [31:0] isrc, input logic [2:0] words, input logic [9:0] opt);
		result_t r;
		r.kind         = kind;
		r.out_handle   = h;
		r.out_mac_dst  = mdst;
		r.out_mac_src  = msrc;
		r.out_ip_dst   = idst;
		r.out_ip_src   = isrc;
		r.header_words = words;
		r.option_code  = opt;
		r.fill_level   = held[WATER_W-1:0];
		r.pause_total  = pauses;
		r.resume_total = resumes;
		r.last         = 1'b0;
		return r;
	endfunction

	// advance the shadow queue by one word and queue the results it causes
	task automatic predict_pkt_events(input item_t w, input bit keep);
		result_t res [$];
		bit      dropped;
		rec_t    r;
		if (w.cmd == CMD_ENQUEUE) begin
			dropped = (held >= QUEUE_DEPTH);
			if (!dropped) begin
				shadow_ring[wr_ptr] = rec_t'(w[REC_W-1:0]);
				wr_ptr = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
				held++;
			end
			// overload on every enqueue above high water, the new packet as template
			if (held > int'(hi_mark)) begin
				pauses++;
				overloaded = 1'b1;
				res.push_back(make_event(KIND_OVERLOAD, w.handle, w.mac_src, w.mac_dst,
					w.ip_src, w.ip_dst, WORDS_MSG, OPT_OVERLOAD));
			end
			if (dropped) begin
				res.push_back(make_event(KIND_DROPPED, w.handle, w.mac_dst, w.mac_src,
					w.ip_dst, w.ip_src, WORDS_PLAIN, OPT_NONE));
			end
		end else if (held == 0) begin
			res.push_back(make_event(KIND_EMPTY, '0, '0, '0, '0, '0, WORDS_PLAIN,
				OPT_NONE));
		end else begin
			r = shadow_ring[rd_ptr];
			rd_ptr = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
			held--;
			// underload only ends an overload, popped packet as template
			if (held < int'(lo_mark) && overloaded) begin
				resumes++;
				overloaded = 1'b0;
				res.push_back(make_event(KIND_UNDERLOAD, r.handle, r.mac_src, r.mac_dst,
					r.ip_src, r.ip_dst, WORDS_MSG, OPT_UNDERLOAD));
			end
			res.push_back(make_event(KIND_SENT, r.handle, r.mac_dst, r.mac_src,
				r.ip_dst, r.ip_src, WORDS_PLAIN, OPT_NONE));
		end
		if (res.size() > 0) begin
			res[$].last = 1'b1;
		end
		if (keep) begin
			foreach (res[k]) begin
				pkt_events_due.push_back(res[k]);
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at cycle %0d on %s: got %h, want %h", cycles, field, got, want);
		mismatches++;
	endtask

	// check each result word against the oldest one due
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (pkt_events_due.size() == 0) begin
				report_mismatch("unexpected word", 64'(result.kind), '0);
			end else begin
				want = pkt_events_due.pop_front();
				if (result.kind !== want.kind)
					report_mismatch("kind", 64'(result.kind), 64'(want.kind));
				if (result.out_handle !== want.out_handle)
					report_mismatch("out_handle", 64'(result.out_handle),
						64'(want.out_handle));
				if (result.out_mac_dst !== want.out_mac_dst)
					report_mismatch("out_mac_dst", 64'(result.out_mac_dst),
						64'(want.out_mac_dst));
				if (result.out_mac_src !== want.out_mac_src)
					report_mismatch("out_mac_src", 64'(result.out_mac_src),
						64'(want.out_mac_src));
				if (result.out_ip_dst !== want.out_ip_dst)
					report_mismatch("out_ip_dst", 64'(result.out_ip_dst),
						64'(want.out_ip_dst));
				if (result.out_ip_src !== want.out_ip_src)
					report_mismatch("out_ip_src", 64'(result.out_ip_src),
						64'(want.out_ip_src));
				if (result.header_words !== want.header_words)
					report_mismatch("header_words", 64'(result.header_words),
						64'(want.header_words));
				if (result.option_code !== want.option_code)
					report_mismatch("option_code", 64'(result.option_code),
						64'(want.option_code));
				if (result.fill_level !== want.fill_level)
					report_mismatch("fill_level", 64'(result.fill_level),
						64'(want.fill_level));
				if (result.pause_total !== want.pause_total)
					report_mismatch("pause_total", 64'(result.pause_total),
						64'(want.pause_total));
				if (result.resume_total !== want.resume_total)
					report_mismatch("resume_total", 64'(result.resume_total),
						64'(want.resume_total));
				if (result.last !== want.last)
					report_mismatch("last", 64'(result.last), 64'(want.last));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// present one word and hold it until the block takes it
	task automatic send_word(input item_t w, input bit keep);
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_pkt_events(w, keep);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// drain every due word, then let in-flight words without results settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pkt_events_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_waters(input logic [WATER_W-1:0] hi, input logic [WATER_W-1:0] lo);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HIGH_WATER;
		cfg_data  <= hi;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_LOW_WATER;
		cfg_data  <= lo;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		hi_mark = hi;
		lo_mark = lo;
	endtask

	task automatic add_row(input item_t w, input bit has_lit, input result_t lit);
		row_t r;
		r.is_cfg  = 1'b0;
		r.hi      = '0;
		r.lo      = '0;
		r.w       = w;
		r.has_lit = has_lit;
		r.lit     = lit;
		script.push_back(r);
	endtask

	task automatic add_cfg(input logic [WATER_W-1:0] hi, input logic [WATER_W-1:0] lo);
		row_t r;
		r.is_cfg  = 1'b1;
		r.hi      = hi;
		r.lo      = lo;
		r.w       = '0;
		r.has_lit = 1'b0;
		r.lit     = '0;
		script.push_back(r);
	endtask

	// random phase at one watermark setting
	task automatic run_phase(input logic [WATER_W-1:0] hi, input logic [WATER_W-1:0] lo,
		input int count, input int enq_pct, input bit with_gaps, input int hold_at);
		item_t w;
		bit    gap_mode;
		wait_idle();
		set_waters(hi, lo);
		gap_mode = 1'b0;
		for (int i = 0; i < count; i++) begin
			// gaps come and go in stretches
			if (i % 40 == 0) begin
				gap_mode = with_gaps && ($urandom_range(2) != 0);
			end
			if (i == hold_at) begin
				wait_idle();
			end
			w.cmd     = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_SEND;
			w.handle  = 16'($urandom());
			w.mac_src = {16'($urandom()), $urandom()};
			w.mac_dst = {16'($urandom()), $urandom()};
			w.ip_src  = $urandom();
			w.ip_dst  = $urandom();
			send_word(w, 1'b1);
			if (gap_mode && $urandom_range(3) == 0) begin
				idle_for($urandom_range(1, 10));
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_HIGH_WATER;
		cfg_data   = '0;
		rd_ptr     = '0;
		wr_ptr     = '0;
		held       = 0;
		overloaded = 1'b0;
		pauses     = '0;
		resumes    = '0;
		hi_mark    = 11'd819;
		lo_mark    = 11'd204;
		mismatches = 0;
		cycles     = 0;

		// reset watermarks: empty pop, plain fill and drain with extreme payloads
		add_row(SLOT_ZERO, 1'b1, EMPTY_AT_RESET);
		add_row(enq(16'hffff, {48{1'b1}}, {48{1'b1}}, 32'hffff_ffff, 32'hffff_ffff),
			1'b0, '0);
		add_row(enq(16'h0, 48'h0, 48'h0, 32'h0, 32'h0), 1'b0, '0);
		add_row(SLOT_ONES, 1'b0, '0);
		add_row(SLOT_ZERO, 1'b0, '0);
		add_row(SLOT_ONES, 1'b0, '0);
		// high water zero: overload on every enqueue, underload back at empty
		add_cfg(11'd0, 11'd1);
		add_row(enq(16'hffff, {48{1'b1}}, {48{1'b1}}, 32'hffff_ffff, 32'hffff_ffff),
			1'b1, FIRST_OVERLOAD_ONES);
		add_row(SLOT_ZERO, 1'b0, '0);
		add_row(enq(16'h1234, 48'h0123_4567_89ab, 48'hfedc_ba98_7654,
			32'hc0a8_0001, 32'h0a00_0002), 1'b0, '0);
		add_row(enq(16'h8001, 48'h8000_0000_0001, 48'h0000_0000_0080,
			32'h8000_0001, 32'h0000_0100), 1'b0, '0);
		add_row(SLOT_ONES, 1'b0, '0);
		add_row(SLOT_ZERO, 1'b0, '0);
		// widest watermarks: never overloaded
		add_cfg(11'd1024, 11'd0);
		add_row(enq(16'h5a5a, 48'ha5a5_a5a5_a5a5, 48'h5a5a_5a5a_5a5a,
			32'hdead_beef, 32'h0bad_f00d), 1'b0, '0);
		add_row(SLOT_ZERO, 1'b0, '0);
		add_row(SLOT_ONES, 1'b0, '0);
		// low water at the top: underload on the first pop after overload
		add_cfg(11'd1, 11'd1024);
		add_row(enq(16'h0f0f, 48'h1111_2222_3333, 48'h4444_5555_6666,
			32'h0102_0304, 32'h0506_0708), 1'b0, '0);
		add_row(enq(16'hf0f0, 48'h7777_8888_9999, 48'haaaa_bbbb_cccc,
			32'h090a_0b0c, 32'h0d0e_0f10), 1'b0, '0);
		add_row(SLOT_ZERO, 1'b0, '0);
		add_row(SLOT_ONES, 1'b0, '0);
		add_row(SLOT_ZERO, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				wait_idle();
				set_waters(script[i].hi, script[i].lo);
			end else begin
				send_word(script[i].w, !script[i].has_lit);
				if (script[i].has_lit) begin
					pkt_events_due.push_back(script[i].lit);
				end
			end
		end

		// shallow queue, tight watermarks
		run_phase(11'd3, 11'd2, 250, 50, 1'b1, -1);
		run_phase(11'($urandom_range(0, 16)), 11'($urandom_range(0, 16)), 250, 55, 1'b1, 125);
		// fill past full so packets drop
		run_phase(11'd1024, 11'd0, 1100, 98, 1'b1, -1);
		// hover near full with overload and underload close together
		run_phase(11'd1022, 11'd1018, 200, 50, 1'b1, 100);
		// extremes, back to back with no gaps
		run_phase(11'd0, 11'd1024, 120, 50, 1'b0, -1);

		wait_idle();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
